### sv/hvp_pkg.sv
// shared types and constants of the hypercube vertex projector
package hvp_pkg;

	localparam int ROWS        = 3;
	localparam int COEF_W      = 16;
	localparam int ROW_W       = 20;
	localparam int MAG_W       = ROW_W - 1;
	localparam int Z_W         = 25;
	localparam int DEN_W       = Z_W - 1;
	localparam int FOC_W       = 24;
	localparam int FOC_SHIFT   = 4;
	localparam int NUM_W       = MAG_W + FOC_W + FOC_SHIFT;
	localparam int Q_W         = 24;
	localparam int SCR_W       = 24;
	localparam int DEPTH_W     = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic       CMD_LOAD    = 1'b0;
	localparam logic       CMD_PROJECT = 1'b1;

	localparam logic [1:0] CFG_DIMENSION = 2'd0;
	localparam logic [1:0] CFG_FOCAL     = 2'd1;
	localparam logic [1:0] CFG_VIEW      = 2'd2;

	localparam logic [3:0]              DIM_MIN      = 4'd3;
	localparam logic [3:0]              DIM_RESET    = 4'd4;
	localparam logic [FOC_W-1:0]        FOCAL_RESET  = 24'd65536;
	localparam logic signed [SCR_W-1:0] VIEW_RESET   = 24'sd20480;
	localparam logic [Q_W-1:0]          SCR_POS_LIM  = 24'h7FFFFF;
	localparam logic [Q_W-1:0]          SCR_NEG_LIM  = 24'h800000;

	typedef struct packed {
		logic                     command;
		logic [1:0]               coef_row;
		logic [2:0]               coef_col;
		logic signed [COEF_W-1:0] coef_value;
		logic [7:0]               vertex_index;
	} item_t;

	typedef struct packed {
		logic [7:0]                vertex_id;
		logic signed [SCR_W-1:0]   screen_x;
		logic signed [SCR_W-1:0]   screen_y;
		logic [DEPTH_W-1:0]        depth;
		logic                      behind_camera;
	} result_t;

	// one classified projection waiting for the back end
	typedef struct packed {
		logic [7:0]              vertex_id;
		logic signed [ROW_W-1:0] x;
		logic signed [ROW_W-1:0] y;
		logic signed [Z_W-1:0]   z;
	} entry_t;

endpackage

### sv/hvp_front.sv
// front end: coefficient matrix, command decode and row sums
module hvp_front #(
	parameter int MAX_DIM = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  hvp_pkg::item_t                item,
	input  logic [3:0]                    dimension,
	input  logic signed [hvp_pkg::SCR_W-1:0] view_offset,
	input  logic                          queue_full,
	output logic                          push,
	output hvp_pkg::entry_t               push_data
);
	import hvp_pkg::*;

	logic signed [COEF_W-1:0] coef_q [ROWS][MAX_DIM];
	logic signed [ROW_W-1:0]  sum_c [ROWS];
	logic [3:0]               dim_eff;
	logic                     accept;

	assign item_stall = queue_full;
	assign accept     = item_valid && !queue_full;
	assign push       = accept && (item.command == CMD_PROJECT);

	always_comb begin
		if (dimension < DIM_MIN) begin
			dim_eff = DIM_MIN;
		end else if (dimension > 4'(MAX_DIM)) begin
			dim_eff = 4'(MAX_DIM);
		end else begin
			dim_eff = dimension;
		end
	end

	// signed sum of each row under the +1/-1 vertex coordinates
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			sum_c[r] = '0;
			for (int k = 0; k < MAX_DIM; k++) begin
				if (4'(k) < dim_eff) begin
					if (item.vertex_index[k]) begin
						sum_c[r] = sum_c[r] - ROW_W'(coef_q[r][k]);
					end else begin
						sum_c[r] = sum_c[r] + ROW_W'(coef_q[r][k]);
					end
				end
			end
		end
	end

	always_comb begin
		push_data.vertex_id = item.vertex_index;
		push_data.x         = sum_c[0];
		push_data.y         = sum_c[1];
		push_data.z         = Z_W'(sum_c[2]) + Z_W'(view_offset);
	end

	// rows or columns outside the matrix match no entry and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < MAX_DIM; c++) begin
					coef_q[r][c] <= '0;
				end
			end
		end else if (accept && (item.command == CMD_LOAD)) begin
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < MAX_DIM; c++) begin
					if ((item.coef_row == 2'(r)) && (item.coef_col == 3'(c))) begin
						coef_q[r][c] <= item.coef_value;
					end
				end
			end
		end
	end

endmodule

### sv/hvp_fifo.sv
// short queue between front end and back end
module hvp_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hvp_pkg::entry_t push_data,
	output logic            full,
	output logic            head_valid,
	output hvp_pkg::entry_t head,
	input  logic            pop
);
	import hvp_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### sv/hvp_div.sv
// pipelined restoring divider, one quotient bit per stage
module hvp_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [hvp_pkg::NUM_W-1:0]   num,
	input  logic [hvp_pkg::DEN_W-1:0]   den,
	output logic [hvp_pkg::Q_W-1:0]     quotient
);
	import hvp_pkg::*;

	logic [NUM_W-1:0] rem_s [Q_W+1];
	logic [DEN_W-1:0] den_s [Q_W+1];
	logic [Q_W-1:0]   q_s   [Q_W+1];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign q_s[0]   = '0;
	assign quotient = q_s[Q_W];

	// numerator is below den * 2^Q_W, so the quotient fits Q_W bits
	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [NUM_W:0] shifted;
		logic [NUM_W:0] diff;

		assign shifted = (NUM_W + 1)'(den_s[i]) << (Q_W - 1 - i);
		assign diff    = {1'b0, rem_s[i]} - shifted;

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				if (!diff[NUM_W]) begin
					rem_s[i+1] <= diff[NUM_W-1:0];
					q_s[i+1]   <= q_s[i] | (Q_W'(1) << (Q_W - 1 - i));
				end else begin
					rem_s[i+1] <= rem_s[i];
					q_s[i+1]   <= q_s[i];
				end
			end
		end
	end

endmodule

### sv/hvp_back.sv
// back end: products, depth, perspective divide and result register
module hvp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  hvp_pkg::entry_t             head,
	output logic                        pop,
	input  logic [hvp_pkg::FOC_W-1:0]   focal_length,
	output logic                        result_valid,
	input  logic                        result_stall,
	output hvp_pkg::result_t            result
);
	import hvp_pkg::*;

	typedef struct packed {
		logic [7:0]         id;
		logic               xneg;
		logic               yneg;
		logic               behind;
		logic               xbig;
		logic               ybig;
		logic [DEPTH_W-1:0] depth;
	} side_t;

	logic en;

	logic               v_s1, v_s2, v_s3;
	logic [7:0]         id_s1, id_s2;
	logic               xneg_s1, yneg_s1, behind_s1;
	logic               xneg_s2, yneg_s2, behind_s2;
	logic [MAG_W-1:0]   xmag_s1, ymag_s1;
	logic [DEN_W-1:0]   zmag_s1, zmag_s2, zmag_s3;
	logic [MAG_W+FOC_W-1:0] px_s2, py_s2;
	logic [2*MAG_W-1:0] xx_s2, yy_s2;
	logic [2*DEN_W-1:0] zz_s2;
	logic [NUM_W-1:0]   numx_s3, numy_s3;
	side_t              side_s3;

	logic [ROW_W-1:0]   xabs, yabs;
	logic [Z_W-1:0]     zabs;
	logic [NUM_W-1:0]   numx, numy;
	logic [NUM_W:0]     den_top;
	logic [2*DEN_W:0]   dsum;

	logic               vd_s  [Q_W+1];
	side_t              sd_s  [Q_W+1];
	logic [Q_W-1:0]     qx, qy;
	result_t            res_c;

	assign en           = !(result_valid && result_stall);
	assign pop          = head_valid && en;

	assign xabs = head.x[ROW_W-1] ? ROW_W'(-head.x) : ROW_W'(head.x);
	assign yabs = head.y[ROW_W-1] ? ROW_W'(-head.y) : ROW_W'(head.y);
	assign zabs = head.z[Z_W-1]   ? Z_W'(-head.z)   : Z_W'(head.z);

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			id_s1     <= head.vertex_id;
			xneg_s1   <= head.x[ROW_W-1];
			yneg_s1   <= head.y[ROW_W-1];
			behind_s1 <= (head.z <= 0);
			xmag_s1   <= xabs[MAG_W-1:0];
			ymag_s1   <= yabs[MAG_W-1:0];
			zmag_s1   <= zabs[DEN_W-1:0];
		end
	end

	// stage 2: focal products and squares
	always_ff @(posedge clk) begin
		if (en) begin
			id_s2     <= id_s1;
			xneg_s2   <= xneg_s1;
			yneg_s2   <= yneg_s1;
			behind_s2 <= behind_s1;
			zmag_s2   <= zmag_s1;
			px_s2     <= (MAG_W+FOC_W)'(xmag_s1) * (MAG_W+FOC_W)'(focal_length);
			py_s2     <= (MAG_W+FOC_W)'(ymag_s1) * (MAG_W+FOC_W)'(focal_length);
			xx_s2     <= (2*MAG_W)'(xmag_s1) * (2*MAG_W)'(xmag_s1);
			yy_s2     <= (2*MAG_W)'(ymag_s1) * (2*MAG_W)'(ymag_s1);
			zz_s2     <= (2*DEN_W)'(zmag_s1) * (2*DEN_W)'(zmag_s1);
		end
	end

	// stage 3: depth sum, overflow check of the quotient
	assign numx    = {px_s2, FOC_SHIFT'(0)};
	assign numy    = {py_s2, FOC_SHIFT'(0)};
	assign den_top = {zmag_s2, Q_W'(0)};
	assign dsum    = (2*DEN_W+1)'(xx_s2) + (2*DEN_W+1)'(yy_s2) + (2*DEN_W+1)'(zz_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s3        <= numx;
			numy_s3        <= numy;
			zmag_s3        <= zmag_s2;
			side_s3.id     <= id_s2;
			side_s3.xneg   <= xneg_s2;
			side_s3.yneg   <= yneg_s2;
			side_s3.behind <= behind_s2;
			side_s3.xbig   <= ((NUM_W+1)'(numx) >= den_top);
			side_s3.ybig   <= ((NUM_W+1)'(numy) >= den_top);
			side_s3.depth  <= dsum[2*DEN_W] ? '1 : dsum[DEPTH_W-1:0];
		end
	end

	hvp_div u_div_x (
		.clk      (clk),
		.en       (en),
		.num      (numx_s3),
		.den      (zmag_s3),
		.quotient (qx)
	);

	hvp_div u_div_y (
		.clk      (clk),
		.en       (en),
		.num      (numy_s3),
		.den      (zmag_s3),
		.quotient (qy)
	);

	// sideband travels alongside the divider stages
	assign vd_s[0] = v_s3;
	assign sd_s[0] = side_s3;

	for (genvar i = 0; i < Q_W; i++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[i+1] <= 1'b0;
			end else if (en) begin
				vd_s[i+1] <= vd_s[i];
			end
		end
	end

	function automatic logic [SCR_W-1:0] finish(input logic neg, input logic big,
			input logic [Q_W-1:0] q);
		if (!neg) begin
			finish = (big || (q > SCR_POS_LIM)) ? SCR_POS_LIM : q;
		end else begin
			finish = (big || (q > SCR_NEG_LIM)) ? SCR_NEG_LIM : (SCR_W'(0) - q);
		end
	endfunction

	always_comb begin
		res_c.vertex_id     = sd_s[Q_W].id;
		res_c.depth         = sd_s[Q_W].depth;
		res_c.behind_camera = sd_s[Q_W].behind;
		if (sd_s[Q_W].behind) begin
			res_c.screen_x = '0;
			res_c.screen_y = '0;
		end else begin
			res_c.screen_x = finish(sd_s[Q_W].xneg, sd_s[Q_W].xbig, qx);
			res_c.screen_y = finish(sd_s[Q_W].yneg, sd_s[Q_W].ybig, qy);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			v_s1         <= pop;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			result_valid <= vd_s[Q_W];
		end
	end

endmodule

### sv/hypercube_vertex_projector.sv
// top level of the hypercube vertex projector: config registers and the two halves
// throughput: one item per cycle unless the queue is full or result_stall holds the back end
// the back end is a 3-stage front plus a 24-stage divider
// loads finish in the cycle they are accepted and give no result
// reset (arst_n low) clears the matrix to zero, empties the queue and the pipeline,
// and loads dimension 4, focal_length 65536, view_offset 20480
module hypercube_vertex_projector #(
	parameter int MAX_DIM = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  hvp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output hvp_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import hvp_pkg::*;

	logic [3:0]              dimension_q;
	logic [FOC_W-1:0]        focal_q;
	logic signed [SCR_W-1:0] view_q;

	logic   push;
	entry_t push_data;
	logic   queue_full;
	logic   head_valid;
	entry_t head;
	logic   pop;

	// config writes are always taken; indexes past the list are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= DIM_RESET;
			focal_q     <= FOCAL_RESET;
			view_q      <= VIEW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DIMENSION: dimension_q <= cfg_data[3:0];
				CFG_FOCAL:     focal_q     <= cfg_data;
				CFG_VIEW:      view_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: takes loads and projections unless the queue is full, applies loads, builds row sums
	hvp_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.dimension   (dimension_q),
		.view_offset (view_q),
		.queue_full  (queue_full),
		.push        (push),
		.push_data   (push_data)
	);

	// queue decouples front stalls from back-end stalls
	hvp_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: products, depth, pipelined divide, registered result
	hvp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.focal_length (focal_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
